// ===== sv/dpss_pkg.sv =====
// Drive power state sequencer package: codes, payload types, route table and
// status word decoder. Depends on nothing; every other file but dpss_ifs uses it.
`timescale 1ns / 1ps
`default_nettype none

package dpss_pkg;

   typedef enum logic [1:0] {
      OP_REQUEST   = 2'd0,
      OP_WRITE_ACK = 2'd1,
      OP_STATUS    = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_SEND   = 2'd0,
      KIND_OK     = 2'd1,
      KIND_ERR    = 2'd2,
      KIND_REPORT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PS_NOT_READY   = 3'd0,
      PS_SO_DISABLED = 3'd1,
      PS_READY       = 3'd2,
      PS_SWITCHED_ON = 3'd3,
      PS_OP_ENABLED  = 3'd4,
      PS_QUICK_STOP  = 3'd5,
      PS_FAULT_REACT = 3'd6,
      PS_FAULT       = 3'd7
   } power_state_type;

   localparam logic [7:0] CW_SHUTDOWN        = 8'h06;
   localparam logic [7:0] CW_SWITCH_ON       = 8'h07;
   localparam logic [7:0] CW_ENABLE_OP       = 8'h0F;
   localparam logic [7:0] CW_DISABLE_VOLTAGE = 8'h00;
   localparam logic [7:0] CW_QUICK_STOP      = 8'h02;
   localparam logic [7:0] CW_FAULT_RESET     = 8'h80;

   typedef struct packed {
      opcode_type      opcode;
      power_state_type target_state;
      logic            write_ok;
      logic [15:0]     status_word;
   } req_type;

   typedef struct packed {
      kind_type        result_kind;
      logic [7:0]      control_word;
      power_state_type power_state;
      logic            node_operating;
   } rsp_type;

   typedef struct packed {
      logic            has_result;
      rsp_type         rsp;
   } core_out_type;

   typedef struct packed {
      logic            found;
      logic [7:0]      word;
      power_state_type next;
   } step_type;

   typedef struct packed {
      logic            hit;
      power_state_type state;
   } decode_type;

   // Next transition from cur toward tgt; found is low when no route exists.
   function automatic step_type pick_step(power_state_type cur, power_state_type tgt);
      step_type s;
      s.found = 1'b0;
      s.word  = CW_DISABLE_VOLTAGE;
      s.next  = PS_NOT_READY;
      unique case (cur)
         PS_FAULT: begin
            s = '{1'b1, CW_FAULT_RESET, PS_SO_DISABLED};
         end
         PS_QUICK_STOP: begin
            if (tgt == PS_OP_ENABLED) begin
               s = '{1'b1, CW_ENABLE_OP, PS_OP_ENABLED};
            end else if (tgt inside {PS_SO_DISABLED, PS_READY, PS_SWITCHED_ON}) begin
               s = '{1'b1, CW_DISABLE_VOLTAGE, PS_SO_DISABLED};
            end
         end
         PS_OP_ENABLED: begin
            if (tgt == PS_SWITCHED_ON) begin
               s = '{1'b1, CW_SWITCH_ON, PS_SWITCHED_ON};
            end else if (tgt == PS_READY) begin
               s = '{1'b1, CW_SHUTDOWN, PS_READY};
            end else if (tgt == PS_SO_DISABLED) begin
               s = '{1'b1, CW_DISABLE_VOLTAGE, PS_SO_DISABLED};
            end else if (tgt == PS_QUICK_STOP) begin
               s = '{1'b1, CW_QUICK_STOP, PS_QUICK_STOP};
            end
         end
         PS_SO_DISABLED: begin
            if (tgt inside {PS_OP_ENABLED, PS_READY, PS_SWITCHED_ON}) begin
               s = '{1'b1, CW_SHUTDOWN, PS_READY};
            end
         end
         PS_SWITCHED_ON: begin
            if (tgt == PS_OP_ENABLED) begin
               s = '{1'b1, CW_ENABLE_OP, PS_OP_ENABLED};
            end else if (tgt == PS_READY) begin
               s = '{1'b1, CW_SHUTDOWN, PS_READY};
            end else if (tgt == PS_SO_DISABLED) begin
               s = '{1'b1, CW_QUICK_STOP, PS_SO_DISABLED};
            end
         end
         PS_READY: begin
            if (tgt inside {PS_OP_ENABLED, PS_SWITCHED_ON}) begin
               s = '{1'b1, CW_SWITCH_ON, PS_SWITCHED_ON};
            end else if (tgt == PS_SO_DISABLED) begin
               s = '{1'b1, CW_QUICK_STOP, PS_SO_DISABLED};
            end
         end
         default: begin
            s.found = 1'b0;
         end
      endcase
      return s;
   endfunction

   // Standard status word masks; hit is low for an unmatched pattern.
   function automatic decode_type decode_status(logic [15:0] sw);
      decode_type d;
      d.hit   = 1'b0;
      d.state = PS_NOT_READY;
      if (sw[3]) begin
         if ((sw & 16'h004F) == 16'h000F) begin
            d = '{1'b1, PS_FAULT_REACT};
         end else if ((sw & 16'h004F) == 16'h0008) begin
            d = '{1'b1, PS_FAULT};
         end
      end else if (sw[6]) begin
         d = '{1'b1, PS_SO_DISABLED};
      end else if (!sw[5]) begin
         if ((sw & 16'h006F) == 16'h0007) begin
            d = '{1'b1, PS_QUICK_STOP};
         end else if ((sw & 16'h004F) == 16'h0000) begin
            d = '{1'b1, PS_NOT_READY};
         end
      end else if (sw[2]) begin
         d = '{1'b1, PS_OP_ENABLED};
      end else if (sw[1]) begin
         d = '{1'b1, PS_SWITCHED_ON};
      end else if (sw[0]) begin
         d = '{1'b1, PS_READY};
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== sv/dpss_ifs.sv =====
// Valid/ready channel interfaces for the sequencer's event and result streams.
// Plain widths of the event and result fields; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface dpss_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [2:0]  target_state;
   logic        write_ok;
   logic [15:0] status_word;

   modport source (output valid, output opcode, output target_state,
                   output write_ok, output status_word, input ready);
   modport sink   (input valid, input opcode, input target_state,
                   input write_ok, input status_word, output ready);
endinterface

interface dpss_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] control_word;
   logic [2:0] power_state;
   logic       node_operating;

   modport source (output valid, output result_kind, output control_word,
                   output power_state, output node_operating, input ready);
   modport sink   (input valid, input result_kind, input control_word,
                   input power_state, input node_operating, output ready);
endinterface

`default_nettype wire

// ===== sv/drive_power_state_sequencer.sv =====
// Drive power state sequencer: event register, decision core, result register.
// An event is registered in the event register, decided by the core and registered in the result register.
// Throughput: one event per cycle while rsp_if takes results; each event is decided in a single pass
// through the core, with the state registers updated as it leaves the event register.
// Reset (synchronous): not ready to switch on, idle, both stages empty.
// Depends on dpss_pkg, dpss_ifs, dpss_core and dpss_rsp_stage.
`timescale 1ns / 1ps
`default_nettype none

module drive_power_state_sequencer (
   input  wire        clock,
   input  wire        reset,
   dpss_req_if.sink   req_if,
   dpss_rsp_if.source rsp_if
);

   // Event register: holds one accepted event until the core can decide it.
   logic              evt_valid_ff, evt_valid_in;
   dpss_pkg::req_type evt_ff;
   dpss_pkg::req_type evt_in;

   logic                   rsp_can_load;
   logic                   evt_fire;
   dpss_pkg::core_out_type core_out;

   // Advance the event when the result register has room; events without a
   // result (idle acknowledgement, unused opcode) just drop without changing state.
   assign evt_fire = evt_valid_ff && rsp_can_load;

   // Take a new event when the register is empty or drains this cycle.
   assign req_if.ready = !evt_valid_ff || evt_fire;

   always_comb begin
      evt_in.opcode       = dpss_pkg::opcode_type'(req_if.opcode);
      evt_in.target_state = dpss_pkg::power_state_type'(req_if.target_state);
      evt_in.write_ok     = req_if.write_ok;
      evt_in.status_word  = req_if.status_word;

      evt_valid_in = evt_valid_ff && !evt_fire;
      if (req_if.valid && req_if.ready) begin
         evt_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
      end else begin
         evt_valid_ff <= evt_valid_in;
      end
   end

   // Payload needs no reset; capture on every input transfer.
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         evt_ff <= evt_in;
      end
   end

   dpss_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (evt_fire),
      .item   (evt_ff),
      .result (core_out)
   );

   dpss_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (evt_fire && core_out.has_result),
      .load_data (core_out.rsp),
      .can_load  (rsp_can_load),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire

// ===== sv/dpss_core.sv =====
// Sequencer state registers and the per-event decision logic.
// Uses dpss_pkg for types, route table and status decoder.
`timescale 1ns / 1ps
`default_nettype none

module dpss_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   fire,
   input  dpss_pkg::req_type     item,
   output dpss_pkg::core_out_type result
);

   dpss_pkg::power_state_type power_state_ff, power_state_in;
   dpss_pkg::power_state_type target_ff, target_in;
   dpss_pkg::power_state_type pending_ff, pending_in;
   logic                      busy_ff, busy_in;
   logic                      operating_ff, operating_in;

   dpss_pkg::power_state_type cur;
   dpss_pkg::power_state_type tgt;
   dpss_pkg::step_type        step;
   dpss_pkg::decode_type      dec;
   dpss_pkg::kind_type        adv_kind;
   logic [7:0]                adv_word;
   logic                      adv_busy;

   always_comb begin
      // Current state seen by the step choice: a good acknowledgement commits first.
      cur  = (item.opcode == dpss_pkg::OP_WRITE_ACK) ? pending_ff : power_state_ff;
      tgt  = (item.opcode == dpss_pkg::OP_REQUEST) ? item.target_state : target_ff;
      step = dpss_pkg::pick_step(cur, tgt);
      dec  = dpss_pkg::decode_status(item.status_word);

      if (cur == tgt) begin
         adv_kind = dpss_pkg::KIND_OK;
         adv_word = 8'h00;
         adv_busy = 1'b0;
      end else if (!step.found) begin
         adv_kind = dpss_pkg::KIND_ERR;
         adv_word = 8'h00;
         adv_busy = 1'b0;
      end else begin
         adv_kind = dpss_pkg::KIND_SEND;
         adv_word = step.word;
         adv_busy = 1'b1;
      end

      power_state_in = power_state_ff;
      target_in      = target_ff;
      pending_in     = pending_ff;
      busy_in        = busy_ff;
      operating_in   = operating_ff;
      result.has_result         = 1'b0;
      result.rsp.result_kind    = dpss_pkg::KIND_OK;
      result.rsp.control_word   = 8'h00;

      case (item.opcode)
         dpss_pkg::OP_REQUEST: begin
            target_in = item.target_state;
            busy_in   = adv_busy;
            if (adv_busy) begin
               pending_in = step.next;
            end
            result.has_result       = 1'b1;
            result.rsp.result_kind  = adv_kind;
            result.rsp.control_word = adv_word;
         end
         dpss_pkg::OP_WRITE_ACK: begin
            if (busy_ff) begin
               result.has_result = 1'b1;
               if (!item.write_ok) begin
                  busy_in                = 1'b0;
                  result.rsp.result_kind = dpss_pkg::KIND_ERR;
               end else begin
                  power_state_in = pending_ff;
                  operating_in   = (pending_ff == dpss_pkg::PS_OP_ENABLED);
                  busy_in        = adv_busy;
                  if (adv_busy) begin
                     pending_in = step.next;
                  end
                  result.rsp.result_kind  = adv_kind;
                  result.rsp.control_word = adv_word;
               end
            end
         end
         dpss_pkg::OP_STATUS: begin
            if (dec.hit) begin
               power_state_in = dec.state;
            end
            result.has_result      = 1'b1;
            result.rsp.result_kind = dpss_pkg::KIND_REPORT;
         end
         default: begin
            result.has_result = 1'b0;
         end
      endcase

      result.rsp.power_state    = power_state_in;
      result.rsp.node_operating = operating_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_state_ff <= dpss_pkg::PS_NOT_READY;
         target_ff      <= dpss_pkg::PS_NOT_READY;
         pending_ff     <= dpss_pkg::PS_NOT_READY;
         busy_ff        <= 1'b0;
         operating_ff   <= 1'b0;
      end else if (fire) begin
         power_state_ff <= power_state_in;
         target_ff      <= target_in;
         pending_ff     <= pending_in;
         busy_ff        <= busy_in;
         operating_ff   <= operating_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/dpss_rsp_stage.sv =====
// Result register that drives the result channel and holds under backpressure.
// Uses dpss_pkg for the result payload type.
`timescale 1ns / 1ps
`default_nettype none

module dpss_rsp_stage (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 load,
   input  dpss_pkg::rsp_type   load_data,
   output logic                can_load,
   dpss_rsp_if.source          rsp_if
);

   logic              valid_ff, valid_in;
   dpss_pkg::rsp_type data_ff;

   // Room when empty or when the held result transfers this cycle.
   assign can_load = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff && !rsp_if.ready;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.result_kind    = data_ff.result_kind;
   assign rsp_if.control_word   = data_ff.control_word;
   assign rsp_if.power_state    = data_ff.power_state;
   assign rsp_if.node_operating = data_ff.node_operating;

endmodule

`default_nettype wire
